FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: hw/rtl/tbmc_pkg.sv
// Package with constants and types of the twelve-bit minicomputer core.
package tbmc_pkg;
	localparam int WORD_BITS_DEF = 12;
	localparam int MEM_DEPTH_DEF = 4096;
	localparam logic [11:0] PC_RESET = 12'o0200;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_READ  = 2'd1,
		FN_EXEC  = 2'd2,
		FN_SETPC = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		OP_AND = 3'd0,
		OP_TAD = 3'd1,
		OP_ISZ = 3'd2,
		OP_DCA = 3'd3,
		OP_JMS = 3'd4,
		OP_JMP = 3'd5,
		OP_IOT = 3'd6,
		OP_OPR = 3'd7
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PTR_RD,
		ST_PTR_WAIT,
		ST_OPND_RD,
		ST_OPND_WAIT,
		ST_EXEC,
		ST_READ_WAIT,
		ST_DONE
	} state_t;
endpackage

FILE: hw/rtl/twelve_bit_minicomputer_core.sv
// Top level of the twelve-bit minicomputer core with its word memory.
`include "assert_macros.svh"
// Memory writes and program counter loads go from ST_PTR_RD to ST_DONE; reads pass through
// ST_READ_WAIT; direct JMP and operate instructions go to ST_EXEC; indirect read-modify-write
// instructions such as an autoindexed ISZ pass ST_PTR_WAIT, ST_OPND_RD and ST_OPND_WAIT. The
// single-port word memory has a registered read, so each pointer or operand access has an
// address state and a read data state. Input is taken only while the core is idle; the result
// waits in an output register, so the next item can start while it waits.
module twelve_bit_minicomputer_core
	import tbmc_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// instruction[11:0], mem_addr[23:12], mem_data[35:24], zeros[39:36]
	input  logic [39:0] s_tdata,
	// func[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// acc[11:0], link_bit[12], prog_counter[24:13], halted[25], read_data[37:26], zeros[39:38]
	output logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata
);
	localparam int AW = $clog2(MEM_DEPTH);
	localparam logic [WORD_BITS-1:0] WMAX = '1;

	logic [WORD_BITS-1:0] mem [MEM_DEPTH];
	logic [WORD_BITS-1:0] rdata_q;
	logic                 mem_we;
	logic [AW-1:0]        mem_addr_c;
	logic [WORD_BITS-1:0] mem_wdata;

	state_t state_q, state_d;
	logic [WORD_BITS-1:0] sw_q, ac_q, pc_q, ins_q, addr_q, data_q, ea_q, rd_q;
	logic link_q, halt_q;
	func_t func_q;
	logic out_valid_q;
	logic [39:0] res_q;
	logic res_load;

	logic [WORD_BITS-1:0] ac_d, pc_d, ea_d, rd_d;
	logic link_d, halt_d;
	logic [WORD_BITS-1:0] direct_a, pc1, eap1;
	logic [WORD_BITS:0] sum;
	logic indirect, autoidx, any, skip;
	logic [2:0] op;
	logic [WORD_BITS-1:0] g1_ac;
	logic g1_l;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr_c] <= mem_wdata;
		end
		rdata_q <= mem[mem_addr_c];
	end

	assign op = ins_q[11:9];
	assign indirect = ins_q[8];
	assign direct_a = {(ins_q[7] ? pc_q[11:7] : 5'd0), ins_q[6:0]};
	assign autoidx = (direct_a[11:3] == 9'd1);
	assign pc1 = pc_q + 12'd1;
	assign eap1 = ea_q + 12'd1;
	assign res_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sw_q <= '0;
			ac_q <= '0;
			link_q <= 1'b0;
			pc_q <= PC_RESET;
			halt_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				sw_q <= cfg_wdata;
			end
			ac_q <= ac_d;
			link_q <= link_d;
			pc_q <= pc_d;
			halt_q <= halt_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= func_t'(s_tuser);
			ins_q <= s_tdata[11:0];
			addr_q <= s_tdata[23:12];
			data_q <= s_tdata[35:24];
		end
		if (res_load) begin
			res_q <= {2'd0, rd_q, halt_q, pc_q, link_q, ac_q};
		end
		ea_q <= ea_d;
		rd_q <= rd_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					state_d = ST_PTR_RD;
				end
			end
			ST_PTR_RD: begin
				case (func_q)
					FN_WRITE, FN_SETPC: state_d = ST_DONE;
					FN_READ: state_d = ST_READ_WAIT;
					default: begin
						if (halt_q) begin
							state_d = ST_DONE;
						end else if (op[2:1] == 2'b11) begin
							state_d = ST_EXEC;
						end else if (indirect) begin
							state_d = ST_PTR_WAIT;
						end else if (op == OP_JMP) begin
							state_d = ST_EXEC;
						end else begin
							state_d = ST_OPND_WAIT;
						end
					end
				endcase
			end
			ST_PTR_WAIT: begin
				state_d = (op == OP_JMP) ? ST_EXEC : ST_OPND_RD;
			end
			ST_OPND_RD: state_d = ST_OPND_WAIT;
			ST_OPND_WAIT: state_d = ST_EXEC;
			ST_READ_WAIT: state_d = ST_DONE;
			ST_EXEC: state_d = ST_DONE;
			ST_DONE: state_d = res_load ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		g1_ac = ac_q;
		g1_l = link_q;
		if (ins_q[7]) g1_ac = '0;
		if (ins_q[6]) g1_l = 1'b0;
		if (ins_q[5]) g1_ac = ~g1_ac;
		if (ins_q[4]) g1_l = ~g1_l;
		if (ins_q[0]) begin
			if (g1_ac == WMAX) g1_l = ~g1_l;
			g1_ac = g1_ac + 12'd1;
		end
		if (ins_q[3] && !ins_q[2]) begin
			{g1_ac, g1_l} = {g1_l, g1_ac};
			if (ins_q[1]) {g1_ac, g1_l} = {g1_l, g1_ac};
		end
		if (ins_q[2] && !ins_q[3]) begin
			{g1_l, g1_ac} = {g1_ac, g1_l};
			if (ins_q[1]) {g1_l, g1_ac} = {g1_ac, g1_l};
		end
		any = (ins_q[6] && ac_q[11]) || (ins_q[5] && ac_q == '0) || (ins_q[4] && link_q);
		skip = ins_q[3] ? !any : any;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_addr_c = direct_a[AW-1:0];
		mem_wdata = '0;
		ac_d = ac_q;
		link_d = link_q;
		pc_d = pc_q;
		halt_d = halt_q;
		ea_d = ea_q;
		rd_d = rd_q;
		sum = {1'b0, ac_q} + {1'b0, rdata_q};
		case (state_q)
			ST_PTR_RD: begin
				ea_d = direct_a;
				rd_d = '0;
				case (func_q)
					FN_WRITE: begin
						mem_we = 1'b1;
						mem_addr_c = addr_q[AW-1:0];
						mem_wdata = data_q;
					end
					FN_READ: mem_addr_c = addr_q[AW-1:0];
					FN_SETPC: begin
						pc_d = addr_q;
						halt_d = 1'b0;
					end
					default: mem_addr_c = direct_a[AW-1:0];
				endcase
			end
			ST_READ_WAIT: rd_d = rdata_q;
			ST_PTR_WAIT: begin
				if (autoidx) begin
					ea_d = rdata_q + 12'd1;
					mem_we = 1'b1;
					mem_addr_c = direct_a[AW-1:0];
					mem_wdata = rdata_q + 12'd1;
				end else begin
					ea_d = rdata_q;
				end
			end
			ST_OPND_RD: mem_addr_c = ea_q[AW-1:0];
			ST_OPND_WAIT: mem_addr_c = ea_q[AW-1:0];
			ST_EXEC: begin
				mem_addr_c = ea_q[AW-1:0];
				pc_d = pc1;
				case (op)
					OP_AND: ac_d = ac_q & rdata_q;
					OP_TAD: begin
						ac_d = sum[WORD_BITS-1:0];
						if (sum[WORD_BITS]) link_d = ~link_q;
					end
					OP_ISZ: begin
						mem_we = 1'b1;
						mem_wdata = rdata_q + 12'd1;
						if (rdata_q == WMAX) pc_d = pc_q + 12'd2;
					end
					OP_DCA: begin
						mem_we = 1'b1;
						mem_wdata = ac_q;
						ac_d = '0;
					end
					OP_JMS: begin
						mem_we = 1'b1;
						mem_wdata = pc1;
						pc_d = eap1;
					end
					OP_JMP: pc_d = ea_q;
					OP_IOT: pc_d = pc1;
					default: begin
						if (!ins_q[8]) begin
							ac_d = g1_ac;
							link_d = g1_l;
						end else if (!ins_q[0]) begin
							if (skip) pc_d = pc_q + 12'd2;
							ac_d = ins_q[7] ? '0 : ac_q;
							if (ins_q[2]) ac_d = ac_d | sw_q;
							if (ins_q[1]) halt_d = 1'b1;
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	`ASSERT_IMPLIES(a_ready_idle, clk, arst_n, s_tready, state_q == ST_IDLE)
	`ASSERT_NEXT(a_done_valid, clk, arst_n, state_q == ST_DONE, m_tvalid)
	`ASSERT_NEXT(a_setpc_clear, clk, arst_n,
		state_q == ST_PTR_RD && func_q == FN_SETPC, !halt_q)
	`ASSERT_NEXT(a_hold_valid, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
endmodule

FILE: verif/twelve_bit_minicomputer_core_tb.sv
// Self-checking testbench of the twelve-bit minicomputer core with its own machine predictor.
module twelve_bit_minicomputer_core_tb;
	import tbmc_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD = 300;

	typedef struct {
		func_t f;
		logic [11:0] ins;
		logic [11:0] addr;
		logic [11:0] data;
	} item_t;

	typedef struct {
		logic [11:0] acc;
		logic lnk;
		logic [11:0] pc;
		logic hlt;
		logic [11:0] rd;
	} machine_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [11:0] cfg_wdata = '0;

	item_t pending_items[$];
	machine_state_t expected_states[$];
	int written_addrs[$];

	logic [11:0] word_mem [0:4095];
	bit word_written [0:4095];
	logic [11:0] m_acc;
	logic m_lnk;
	logic [11:0] m_pc;
	logic m_hlt;
	logic [11:0] m_sw;

	int errors = 0;
	int send_gap = 0;
	int ready_hold = 0;
	int results_seen = 0;
	bit long_hold_done = 0;
	int idle_cycles = 0;

	twelve_bit_minicomputer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic store_word(logic [11:0] a, logic [11:0] v);
		if (!word_written[a]) begin
			written_addrs.push_back(a);
		end
		word_mem[a] = v;
		word_written[a] = 1;
	endtask

	function automatic logic [11:0] direct_addr(logic [11:0] ins, logic [11:0] pc0);
		return {ins[7] ? pc0[11:7] : 5'd0, ins[6:0]};
	endfunction

	// Returns an address that the instruction would read before it was ever written, or -1.
	function automatic int unwritten_operand(logic [11:0] ins);
		logic [11:0] a;
		logic [11:0] ea;
		opcode_t op;
		op = opcode_t'(ins[11:9]);
		if (m_hlt || op == OP_IOT || op == OP_OPR) begin
			return -1;
		end
		a = direct_addr(ins, m_pc);
		ea = a;
		if (ins[8]) begin
			if (!word_written[a]) begin
				return a;
			end
			ea = (a >= 12'o10 && a <= 12'o17) ? word_mem[a] + 12'd1 : word_mem[a];
		end
		if ((op == OP_AND || op == OP_TAD || op == OP_ISZ) && !word_written[ea]) begin
			return ea;
		end
		return -1;
	endfunction

	task automatic run_operate(logic [11:0] ins);
		logic [12:0] sum;
		logic take;
		logic [11:0] ac0;
		ac0 = m_acc;
		if (!ins[8]) begin
			if (ins[7]) m_acc = '0;
			if (ins[6]) m_lnk = 1'b0;
			if (ins[5]) m_acc = ~m_acc;
			if (ins[4]) m_lnk = ~m_lnk;
			if (ins[0]) begin
				sum = m_acc + 13'd1;
				if (sum[12]) m_lnk = ~m_lnk;
				m_acc = sum[11:0];
			end
			repeat (ins[1] ? 2 : 1) begin
				if (ins[3] && !ins[2]) begin
					{m_acc, m_lnk} = {m_lnk, m_acc};
				end else if (ins[2] && !ins[3]) begin
					{m_lnk, m_acc} = {m_acc, m_lnk};
				end
			end
		end else if (!ins[0]) begin
			take = (ins[6] && ac0[11]) || (ins[5] && ac0 == 0) || (ins[4] && m_lnk);
			if (ins[3] ? !take : take) m_pc = m_pc + 12'd1;
			if (ins[7]) m_acc = '0;
			if (ins[2]) m_acc = m_acc | m_sw;
			if (ins[1]) m_hlt = 1'b1;
		end
	endtask

	task automatic run_instruction(logic [11:0] ins);
		logic [11:0] pc0;
		logic [11:0] a;
		logic [11:0] ea;
		logic [11:0] v;
		logic [12:0] sum;
		opcode_t op;
		pc0 = m_pc;
		op = opcode_t'(ins[11:9]);
		ea = '0;
		if (op != OP_IOT && op != OP_OPR) begin
			a = direct_addr(ins, pc0);
			ea = a;
			if (ins[8]) begin
				if (a >= 12'o10 && a <= 12'o17) begin
					store_word(a, word_mem[a] + 12'd1);
				end
				ea = word_mem[a];
			end
		end
		m_pc = pc0 + 12'd1;
		case (op)
			OP_AND: m_acc = m_acc & word_mem[ea];
			OP_TAD: begin
				sum = m_acc + word_mem[ea];
				if (sum[12]) m_lnk = ~m_lnk;
				m_acc = sum[11:0];
			end
			OP_ISZ: begin
				v = word_mem[ea] + 12'd1;
				store_word(ea, v);
				if (v == 0) m_pc = m_pc + 12'd1;
			end
			OP_DCA: begin
				store_word(ea, m_acc);
				m_acc = '0;
			end
			OP_JMS: begin
				store_word(ea, m_pc);
				m_pc = ea + 12'd1;
			end
			OP_JMP: m_pc = ea;
			OP_IOT: ;
			default: run_operate(ins);
		endcase
	endtask

	task automatic queue_item(func_t f, logic [11:0] ins, logic [11:0] addr, logic [11:0] data);
		item_t it;
		machine_state_t e;
		it = '{f: f, ins: ins, addr: addr, data: data};
		e.rd = '0;
		case (f)
			FN_WRITE: store_word(addr, data);
			FN_READ: e.rd = word_mem[addr];
			FN_EXEC: if (!m_hlt) run_instruction(ins);
			default: begin
				m_pc = addr;
				m_hlt = 1'b0;
			end
		endcase
		e.acc = m_acc;
		e.lnk = m_lnk;
		e.pc = m_pc;
		e.hlt = m_hlt;
		pending_items.push_back(it);
		expected_states.push_back(e);
	endtask

	// Words that an item would read are written first, so no uninitialized word is ever read.
	task automatic send(func_t f, logic [11:0] ins, logic [11:0] addr, logic [11:0] data);
		int miss;
		if (f == FN_READ && !word_written[addr]) begin
			queue_item(FN_WRITE, '0, addr, 12'($urandom));
		end
		if (f == FN_EXEC) begin
			miss = unwritten_operand(ins);
			while (miss >= 0) begin
				queue_item(FN_WRITE, '0, 12'(miss), 12'($urandom));
				miss = unwritten_operand(ins);
			end
		end
		queue_item(f, ins, addr, data);
	endtask

	task automatic drain_and_configure(logic [11:0] value);
		while (pending_items.size() != 0 || s_tvalid || expected_states.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		m_sw = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random();
		int pick;
		logic [11:0] a;
		pick = $urandom_range(99);
		if (pick < 55) begin
			send(FN_EXEC, 12'($urandom), '0, '0);
		end else if (pick < 72) begin
			case ($urandom_range(2))
				0: a = 12'($urandom_range(8, 15));
				1: a = {m_pc[11:7], 7'($urandom)};
				default: a = 12'($urandom);
			endcase
			send(FN_WRITE, 12'($urandom), a, 12'($urandom));
		end else if (pick < 88) begin
			if (written_addrs.size() != 0 && $urandom_range(4) != 0) begin
				a = 12'(written_addrs[$urandom_range(written_addrs.size() - 1)]);
			end else begin
				a = 12'($urandom);
			end
			send(FN_READ, 12'($urandom), a, 12'($urandom));
		end else begin
			send(FN_SETPC, 12'($urandom), 12'($urandom), 12'($urandom));
		end
	endtask

	task automatic report(string what, logic [11:0] want, logic [11:0] got);
		errors++;
		$display("mismatch in %s: expected %0o, got %0o", what, want, got);
	endtask

	always @(posedge clk) begin
		item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				it = pending_items.pop_front();
				s_tdata <= {4'd0, it.data, it.addr, it.ins};
				s_tuser <= it.f;
				s_tvalid <= 1'b1;
				case ($urandom_range(19))
					0: send_gap = $urandom_range(10, 40);
					1, 2, 3, 4, 5: send_gap = $urandom_range(1, 3);
					default: send_gap = 0;
				endcase
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (ready_hold > 0) begin
			ready_hold--;
			m_tready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 100) begin
			long_hold_done = 1;
			ready_hold = LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			case ($urandom_range(29))
				0: begin
					ready_hold = $urandom_range(20, 60);
					m_tready <= 1'b0;
				end
				1, 2, 3, 4, 5, 6, 7: begin
					ready_hold = $urandom_range(0, 3);
					m_tready <= 1'b0;
				end
				default: m_tready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		machine_state_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_states.size() == 0) begin
				errors++;
				$display("result arrived with no item outstanding");
			end else begin
				e = expected_states.pop_front();
				if (m_tdata[11:0] !== e.acc) report("acc", e.acc, m_tdata[11:0]);
				if (m_tdata[12] !== e.lnk) report("link_bit", e.lnk, m_tdata[12]);
				if (m_tdata[24:13] !== e.pc) report("prog_counter", e.pc, m_tdata[24:13]);
				if (m_tdata[25] !== e.hlt) report("halted", e.hlt, m_tdata[25]);
				if (m_tdata[37:26] !== e.rd) report("read_data", e.rd, m_tdata[37:26]);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [11:0] directed [$];
		logic [11:0] sw_values [4];
		m_acc = '0;
		m_lnk = 1'b0;
		m_pc = PC_RESET;
		m_hlt = 1'b0;
		m_sw = '0;
		for (int i = 0; i < 4096; i++) begin
			word_written[i] = 0;
			word_mem[i] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drain_and_configure(12'o7777);

		send(FN_WRITE, '0, 12'o7777, 12'o7777);
		send(FN_WRITE, 12'o7777, 12'o0000, 12'o0000);
		send(FN_READ, '0, 12'o7777, '0);
		send(FN_READ, 12'o7777, 12'o0000, 12'o7777);
		send(FN_SETPC, '0, 12'o0000, '0);
		directed = '{12'o7300, 12'o7041, 12'o7020, 12'o7010, 12'o7006, 12'o7014, 12'o7002,
			12'o1377, 12'o0000, 12'o2410, 12'o3200, 12'o4020, 12'o5410, 12'o7500,
			12'o7440, 12'o7420, 12'o7510, 12'o7604, 12'o6001, 12'o7401, 12'o7402, 12'o7001};
		foreach (directed[i]) begin
			send(FN_EXEC, directed[i], '0, '0);
		end
		send(FN_SETPC, '0, 12'o7777, '0);
		send(FN_EXEC, 12'o7001, '0, '0);

		sw_values = '{12'o0000, 12'($urandom), 12'o5252, 12'o7777};
		foreach (sw_values[p]) begin
			drain_and_configure(sw_values[p]);
			repeat (150) send_random();
		end

		while (pending_items.size() != 0 || s_tvalid || expected_states.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/tbmc_pkg.sv
hw/rtl/twelve_bit_minicomputer_core.sv
verif/twelve_bit_minicomputer_core_tb.sv
